// File: src/mvtm_pkg.sv
`default_nettype none

package mvtm_pkg;

	localparam int VOICE_COUNT_DEF = 4;
	localparam int SINE_STEPS_DEF  = 256;
	localparam int DAC_LEVELS_DEF  = 4096;

	localparam int OUT_W      = 12;
	localparam int VIDX_IN_W  = 2;
	localparam int PHASE_W    = 32;
	localparam int PIDX_W     = 24;
	localparam int RAW_W      = 17;
	localparam int MUL_W      = 18;
	localparam int PROD_W     = 2 * MUL_W;
	localparam int VOL_SHIFT  = 16;
	localparam int VOL_ONE    = 65536;
	localparam int NOISE_SHIFT = 4;

	localparam longint unsigned HALF_PI_Q30 = 64'd1686629713;

	typedef enum logic [1:0] {
		KIND_SILENT = 2'd0,
		KIND_SINE   = 2'd1,
		KIND_SQUARE = 2'd2,
		KIND_NOISE  = 2'd3
	} kind_t;

	typedef struct packed {
		kind_t               kind;
		logic [PHASE_W-1:0]  phase;
		logic [15:0]         period;
		logic [15:0]         step;
		logic [15:0]         volume;
		logic [9:0]          decay;
		logic [23:0]         time_left;
	} voice_t;

	// One table entry from the quarter-wave angle x (Q30 radians). The series runs
	// through x^15 and the magnitude is clamped just below half scale.
	function automatic logic signed [RAW_W-1:0] sine_value(
		input logic [63:0] x,
		input logic        neg,
		input logic [63:0] half
	);
		logic [63:0]        term;
		logic signed [63:0] acc;
		logic [63:0]        mag;
		term = x;
		acc  = $signed(x);
		for (int k = 1; k <= 7; k++) begin
			term = (term * x) >> 30;
			term = (term * x) >> 30;
			term = term / 64'((2 * k) * (2 * k + 1));
			if (k % 2 == 1) begin
				acc = acc - $signed(term);
			end else begin
				acc = acc + $signed(term);
			end
		end
		if (acc < 0) begin
			acc = 64'sd0;
		end
		mag = (half * 64'(acc)) >> 30;
		if (mag > half - 64'd1) begin
			mag = half - 64'd1;
		end
		return neg ? -RAW_W'(mag) : RAW_W'(mag);
	endfunction

endpackage

`default_nettype wire

// File: src/mvtm_mul.sv
`default_nettype none

module mvtm_mul (
	input  wire logic                                 clk,
	input  wire logic signed [mvtm_pkg::MUL_W-1:0]    a,
	input  wire logic signed [mvtm_pkg::MUL_W-1:0]    b,
	output logic signed [mvtm_pkg::PROD_W-1:0]        prod
);

	logic signed [mvtm_pkg::PROD_W-1:0] prod_q;

	always_ff @(posedge clk) begin
		prod_q <= a * b;
	end

	assign prod = prod_q;

endmodule

`default_nettype wire

// File: src/mvtm_voice_file.sv
`default_nettype none

module mvtm_voice_file #(
	parameter int VOICE_COUNT = mvtm_pkg::VOICE_COUNT_DEF
) (
	input  wire logic                     clk,
	input  wire logic                     arst_n,
	input  wire logic                     wr_en,
	input  wire logic [((VOICE_COUNT > 1) ? $clog2(VOICE_COUNT) : 1)-1:0] wr_idx,
	input  wire mvtm_pkg::voice_t         wr_rec,
	input  wire logic [((VOICE_COUNT > 1) ? $clog2(VOICE_COUNT) : 1)-1:0] rd_idx,
	output mvtm_pkg::voice_t              rd_rec
);

	mvtm_pkg::voice_t regs_q [VOICE_COUNT];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < VOICE_COUNT; i++) begin
				regs_q[i] <= '0;
			end
		end else if (wr_en) begin
			regs_q[wr_idx] <= wr_rec;
		end
	end

	assign rd_rec = regs_q[rd_idx];

endmodule

`default_nettype wire

// File: src/mvtm_sine_rom.sv
`default_nettype none

module mvtm_sine_rom #(
	parameter int SINE_STEPS = mvtm_pkg::SINE_STEPS_DEF,
	parameter int DAC_LEVELS = mvtm_pkg::DAC_LEVELS_DEF
) (
	input  wire logic                                clk,
	input  wire logic                                arst_n,
	input  wire logic                                start,
	input  wire logic [mvtm_pkg::PIDX_W-1:0]         phase_idx,
	output logic                                     valid,
	output logic signed [mvtm_pkg::RAW_W-1:0]        data
);

	localparam int RI_W    = $clog2(SINE_STEPS);
	localparam bit IS_POW2 = (SINE_STEPS & (SINE_STEPS - 1)) == 0;

	logic signed [mvtm_pkg::RAW_W-1:0] rom_c [SINE_STEPS];

	// Each entry folds its angle into the first quadrant and sets the sign.
	for (genvar n = 0; n < SINE_STEPS; n++) begin : g_rom
		localparam longint unsigned Q    = 4 * n;
		localparam longint unsigned QUAD = Q / SINE_STEPS;
		localparam longint unsigned R    = Q % SINE_STEPS;
		localparam longint unsigned M    = (QUAD % 2 == 1) ? (SINE_STEPS - R) : R;
		localparam longint unsigned X    = (M * mvtm_pkg::HALF_PI_Q30) / SINE_STEPS;
		assign rom_c[n] = mvtm_pkg::sine_value(64'(X), QUAD >= 2, 64'(DAC_LEVELS / 2));
	end

	if (IS_POW2) begin : g_mask
		logic                               valid_q;
		logic signed [mvtm_pkg::RAW_W-1:0]  data_q;

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				valid_q <= 1'b0;
			end else if (start) begin
				valid_q <= 1'b1;
			end
		end

		always_ff @(posedge clk) begin
			if (start) begin
				data_q <= rom_c[phase_idx[RI_W-1:0]];
			end
		end

		assign valid = valid_q;
		assign data  = data_q;
	end else begin : g_rem
		localparam int M_W   = mvtm_pkg::PIDX_W + 2;
		localparam int P_W   = mvtm_pkg::PIDX_W + M_W;
		localparam int SH    = mvtm_pkg::PIDX_W + RI_W;
		localparam int QUO_W = P_W - SH;
		localparam longint unsigned MAGIC =
			((64'd1 << SH) + 64'(SINE_STEPS) - 64'd1) / 64'(SINE_STEPS);

		logic                               valid_q;
		logic                               s1_q;
		logic                               s2_q;
		logic                               s3_q;
		logic [mvtm_pkg::PIDX_W-1:0]        x_q;
		logic [P_W-1:0]                     prod_q;
		logic [RI_W-1:0]                    r_q;
		logic [QUO_W-1:0]                   quo;
		logic [mvtm_pkg::PIDX_W-1:0]        quo_s;
		logic signed [mvtm_pkg::RAW_W-1:0]  data_q;

		// The rounded-up reciprocal gives the exact quotient for every address
		// of this width, so the remainder needs no correction step.
		assign quo   = prod_q[P_W-1:SH];
		assign quo_s = mvtm_pkg::PIDX_W'(quo) * mvtm_pkg::PIDX_W'(SINE_STEPS);

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				valid_q <= 1'b0;
				s1_q    <= 1'b0;
				s2_q    <= 1'b0;
				s3_q    <= 1'b0;
			end else begin
				s1_q <= start;
				s2_q <= s1_q;
				s3_q <= s2_q;
				if (start) begin
					valid_q <= 1'b0;
				end else if (s3_q) begin
					valid_q <= 1'b1;
				end
			end
		end

		always_ff @(posedge clk) begin
			if (start) begin
				x_q <= phase_idx;
			end
			if (s1_q) begin
				prod_q <= P_W'(x_q) * P_W'(MAGIC);
			end
			if (s2_q) begin
				r_q <= RI_W'(x_q - quo_s);
			end
			if (s3_q) begin
				data_q <= rom_c[r_q];
			end
		end

		assign valid = valid_q;
		assign data  = data_q;
	end

endmodule

`default_nettype wire

// File: src/multi_voice_tone_mixer_top.sv
// Load word: taken while idle; in_ready stays high, no result.
// Tick word: one result; each voice is fetched, each sounding voice steps ST_PS, ST_SC, ST_DC, ST_WB,
// and ST_DONE clips the sum; the shared multiplier visits each sounding voice three times in turn.
// A sounding voice waits in ST_PS while the table address is reduced when SINE_STEPS is not a power of two.
// The next word is taken the cycle after the result enters the output register.
// Reset clears every voice to silent with zero state and empties the output register.
`default_nettype none

module multi_voice_tone_mixer_top #(
	parameter int VOICE_COUNT = mvtm_pkg::VOICE_COUNT_DEF,
	parameter int SINE_STEPS  = mvtm_pkg::SINE_STEPS_DEF,
	parameter int DAC_LEVELS  = mvtm_pkg::DAC_LEVELS_DEF
) (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	input  wire logic                              in_valid,
	output logic                                   in_ready,
	input  wire logic                              action,
	input  wire logic [mvtm_pkg::VIDX_IN_W-1:0]    voice_index,
	input  wire logic [1:0]                        wave_type,
	input  wire logic [15:0]                       period,
	input  wire logic [15:0]                       phase_step,
	input  wire logic [15:0]                       start_value,
	input  wire logic [15:0]                       start_volume,
	input  wire logic [9:0]                        decay_rate,
	input  wire logic [23:0]                       duration,
	output logic                                   out_valid,
	input  wire logic                              out_ready,
	output logic [mvtm_pkg::OUT_W-1:0]             mixed_sample
);

	localparam int VIDX_W = (VOICE_COUNT > 1) ? $clog2(VOICE_COUNT) : 1;
	localparam int HALF   = DAC_LEVELS / 2;
	localparam int RAW_W  = mvtm_pkg::RAW_W;
	localparam int MUL_W  = mvtm_pkg::MUL_W;
	localparam int SUM_W  = RAW_W + $clog2(VOICE_COUNT + 1) + 2;

	localparam logic signed [SUM_W-1:0] HALF_S   = SUM_W'(HALF);
	localparam logic signed [SUM_W-1:0] MAX_CODE = SUM_W'(DAC_LEVELS - 1);

	typedef enum logic [6:0] {
		ST_IDLE  = 7'b0000001,
		ST_FETCH = 7'b0000010,
		ST_PS    = 7'b0000100,
		ST_SC    = 7'b0001000,
		ST_DC    = 7'b0010000,
		ST_WB    = 7'b0100000,
		ST_DONE  = 7'b1000000
	} state_t;

	state_t                         state_q;
	logic [VIDX_W-1:0]              vcnt_q;
	mvtm_pkg::voice_t               cur_q;
	logic signed [SUM_W-1:0]        sum_q;
	logic                           out_valid_q;
	logic [mvtm_pkg::OUT_W-1:0]     mixed_q;

	logic                               accept;
	logic                               last;
	logic [4:0]                         vi_ext;
	logic                               load_ok;
	mvtm_pkg::voice_t                   load_rec;
	mvtm_pkg::voice_t                   wb_rec;
	mvtm_pkg::voice_t                   rd_rec;
	logic                               wr_en;
	logic [VIDX_W-1:0]                  wr_idx;
	mvtm_pkg::voice_t                   wr_rec;
	logic                               rom_start;
	logic                               rom_valid;
	logic signed [RAW_W-1:0]            rom_data;
	logic signed [MUL_W-1:0]            mul_a;
	logic signed [MUL_W-1:0]            mul_b;
	logic signed [mvtm_pkg::PROD_W-1:0] prod;
	logic signed [RAW_W-1:0]            scaled;
	logic signed [RAW_W-1:0]            raw;
	logic [15:0]                        lfsr_new;
	logic [mvtm_pkg::PHASE_W-1:0]       phase_inc;
	logic [mvtm_pkg::PHASE_W-1:0]       phase_nxt;
	logic signed [SUM_W-1:0]            total;
	logic signed [SUM_W-1:0]            clipped;

	assign in_ready = (state_q == ST_IDLE);
	assign accept   = in_valid && in_ready;
	assign last     = (vcnt_q == VIDX_W'(VOICE_COUNT - 1));

	assign vi_ext  = 5'(voice_index);
	assign load_ok = (vi_ext < 5'(VOICE_COUNT));

	always_comb begin
		load_rec.kind      = mvtm_pkg::kind_t'(wave_type);
		load_rec.phase     = mvtm_pkg::PHASE_W'(start_value);
		load_rec.period    = period;
		load_rec.step      = phase_step;
		load_rec.volume    = start_volume;
		load_rec.decay     = decay_rate;
		load_rec.time_left = duration;
	end

	always_comb begin
		wb_rec           = cur_q;
		wb_rec.volume    = prod[mvtm_pkg::VOL_SHIFT+15:mvtm_pkg::VOL_SHIFT];
		wb_rec.time_left = cur_q.time_left - 1'b1;
	end

	assign wr_en  = (accept && action && load_ok) || (state_q == ST_WB);
	assign wr_idx = (state_q == ST_WB) ? vcnt_q : vi_ext[VIDX_W-1:0];
	assign wr_rec = (state_q == ST_WB) ? wb_rec : load_rec;

	mvtm_voice_file #(
		.VOICE_COUNT(VOICE_COUNT)
	) u_voice_file (
		.clk    (clk),
		.arst_n (arst_n),
		.wr_en  (wr_en),
		.wr_idx (wr_idx),
		.wr_rec (wr_rec),
		.rd_idx (vcnt_q),
		.rd_rec (rd_rec)
	);

	assign rom_start = (state_q == ST_FETCH) && (rd_rec.time_left != '0);

	mvtm_sine_rom #(
		.SINE_STEPS(SINE_STEPS),
		.DAC_LEVELS(DAC_LEVELS)
	) u_sine_rom (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (rom_start),
		.phase_idx (rd_rec.phase[mvtm_pkg::PHASE_W-1:mvtm_pkg::PHASE_W-mvtm_pkg::PIDX_W]),
		.valid     (rom_valid),
		.data      (rom_data)
	);

	// Raw sample and next phase of the current voice; the sine wrap compares
	// against period * step, which the multiplier registered during ST_PS.
	always_comb begin
		lfsr_new  = {cur_q.phase[0] ^ cur_q.phase[2] ^ cur_q.phase[3] ^ cur_q.phase[5],
			cur_q.phase[15:1]};
		phase_inc = '0;
		unique case (cur_q.kind)
			mvtm_pkg::KIND_NOISE: begin
				raw       = RAW_W'(lfsr_new[15:mvtm_pkg::NOISE_SHIFT]) - RAW_W'(HALF);
				phase_nxt = mvtm_pkg::PHASE_W'(lfsr_new);
			end
			mvtm_pkg::KIND_SQUARE: begin
				raw = (cur_q.phase < mvtm_pkg::PHASE_W'(cur_q.period[15:1])) ?
					RAW_W'(HALF - 1) : -RAW_W'(HALF);
				phase_inc = cur_q.phase + 1'b1;
				phase_nxt = (phase_inc == mvtm_pkg::PHASE_W'(cur_q.period)) ? '0 : phase_inc;
			end
			mvtm_pkg::KIND_SINE: begin
				raw       = rom_data;
				phase_inc = cur_q.phase + mvtm_pkg::PHASE_W'(cur_q.step);
				phase_nxt = (phase_inc >= prod[mvtm_pkg::PHASE_W-1:0]) ? '0 : phase_inc;
			end
			default: begin
				raw       = '0;
				phase_nxt = cur_q.phase;
			end
		endcase
	end

	always_comb begin
		priority if (state_q == ST_PS) begin
			mul_a = $signed(MUL_W'(cur_q.period));
			mul_b = $signed(MUL_W'(cur_q.step));
		end else if (state_q == ST_SC) begin
			mul_a = MUL_W'(raw);
			mul_b = $signed(MUL_W'(cur_q.volume));
		end else begin
			mul_a = $signed(MUL_W'(cur_q.volume));
			mul_b = $signed(MUL_W'(mvtm_pkg::VOL_ONE) - MUL_W'(cur_q.decay));
		end
	end

	mvtm_mul u_mul (
		.clk  (clk),
		.a    (mul_a),
		.b    (mul_b),
		.prod (prod)
	);

	// The arithmetic shift of the product floors toward minus infinity.
	assign scaled = prod[RAW_W+mvtm_pkg::VOL_SHIFT-1:mvtm_pkg::VOL_SHIFT];

	always_comb begin
		total = sum_q + HALF_S;
		priority if (total > MAX_CODE) begin
			clipped = MAX_CODE;
		end else if (total < 0) begin
			clipped = '0;
		end else begin
			clipped = total;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			vcnt_q      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (out_valid_q && out_ready && (state_q != ST_DONE)) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (accept && !action) begin
						vcnt_q  <= '0;
						state_q <= ST_FETCH;
					end
				end
				ST_FETCH: begin
					if (rd_rec.time_left != '0) begin
						state_q <= ST_PS;
					end else if (last) begin
						state_q <= ST_DONE;
					end else begin
						vcnt_q <= vcnt_q + 1'b1;
					end
				end
				ST_PS: begin
					if (rom_valid) begin
						state_q <= ST_SC;
					end
				end
				ST_SC: begin
					state_q <= ST_DC;
				end
				ST_DC: begin
					state_q <= ST_WB;
				end
				ST_WB: begin
					if (last) begin
						state_q <= ST_DONE;
					end else begin
						vcnt_q  <= vcnt_q + 1'b1;
						state_q <= ST_FETCH;
					end
				end
				ST_DONE: begin
					if (!out_valid_q || out_ready) begin
						out_valid_q <= 1'b1;
						state_q     <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_IDLE) begin
			sum_q <= '0;
		end
		if (state_q == ST_FETCH) begin
			cur_q <= rd_rec;
		end
		if (state_q == ST_SC) begin
			cur_q.phase <= phase_nxt;
		end
		if (state_q == ST_DC) begin
			sum_q <= sum_q + SUM_W'(scaled);
		end
		if ((state_q == ST_DONE) && (!out_valid_q || out_ready)) begin
			mixed_q <= clipped[mvtm_pkg::OUT_W-1:0];
		end
	end

	assign out_valid    = out_valid_q;
	assign mixed_sample = mixed_q;

`ifndef SYNTHESIS
	a_vcnt_range: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q != ST_IDLE) |-> (vcnt_q <= VIDX_W'(VOICE_COUNT - 1)))
		else $error("voice counter ran past the last voice");

	a_rom_ready: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_SC) |-> rom_valid)
		else $error("sample scaled before the sine table data was ready");

	a_wb_active: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_WB) |-> (cur_q.time_left != '0))
		else $error("write-back of a voice that had no time left");

	a_out_from_done: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(state_q == ST_DONE))
		else $error("result word appeared without a finished tick");
`endif

endmodule

`default_nettype wire
